// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top file of the softmax row normalizer core.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`endif

// ===== hw/rtl/smx_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the softmax row normalizer.
// Depends on nothing.
package smx_pkg;
	localparam logic [22:0] LOG2E_Q22 = 23'd6051102;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [20:0] EXP_SUM_MAX = 21'h1FFFFF;
	localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;
	localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;
	typedef struct packed {
		logic [15:0] logit;
		logic        row_end;
	} smx_item_t;
endpackage

// ===== hw/rtl/softmax_row_normalizer_core.sv =====
// Softmax row normalizer: after row end, an exponential pass runs over each element
// (per Horner step a multiply, then a divide by reciprocal multiply or shift), then
// the bit-serial divider runs over each element; loading takes one logit per cycle
// while the back part waits for a row, through a two-word queue.
// Reset is asynchronous, active low, and clears the FSM, counters and pointers.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module softmax_row_normalizer_core #(
	parameter int MAX_ROW_LEN = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // logit
	input  logic        s_tlast,  // row_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // probability
	output logic        m_tlast,  // last_of_row
	output logic        m_tuser   // overflowed
);
	import smx_pkg::*;
	smx_item_t in_item, q_item;
	logic q_valid, q_ready;
	assign in_item = '{logit: s_tdata, row_end: s_tlast};
	smx_front u_front (.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.in_item, .q_valid, .q_ready, .q_item);
	smx_back #(.MAX_ROW_LEN(MAX_ROW_LEN)) u_back (.clk, .arst_n, .q_valid, .q_ready,
		.q_item, .out_valid(m_tvalid), .out_ready(m_tready), .probability(m_tdata),
		.last_of_row(m_tlast), .overflowed(m_tuser));
	`ASSERT_IMPL(a_excl, clk, arst_n, m_tvalid, !q_ready)
	`ASSERT_NEXT(a_end, clk, arst_n, m_tvalid && m_tready && m_tlast, q_ready)
endmodule

// ===== hw/rtl/smx_front.sv =====
`timescale 1ns / 1ps
// Front part: registers each accepted word into a two-entry queue.
// Depends on smx_pkg.
module smx_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  smx_pkg::smx_item_t in_item,
	output logic             q_valid,
	input  logic             q_ready,
	output smx_pkg::smx_item_t q_item
);
	import smx_pkg::*;
	smx_item_t mem_q [2];
	logic [0:0] wp_q, rp_q;
	logic [1:0] cnt_q;
	assign in_ready = cnt_q != 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_item = mem_q[rp_q];
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= in_item;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (in_valid && in_ready) wp_q <= wp_q + 1'b1;
			if (q_valid && q_ready) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end
endmodule

// ===== hw/rtl/smx_back.sv =====
`timescale 1ns / 1ps
// Back part: stores a row, computes exponentials and sum, then divides.
// Depends on smx_pkg.
module smx_back #(
	parameter int MAX_ROW_LEN = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_ready,
	input  smx_pkg::smx_item_t q_item,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [15:0]      probability,
	output logic             last_of_row,
	output logic             overflowed
);
	import smx_pkg::*;
	localparam int AW = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
	localparam int CW = $clog2(MAX_ROW_LEN + 1);
	localparam logic [2:0] ST_LOAD = 3'd0, ST_RD = 3'd1, ST_EXP = 3'd2,
		ST_DRD = 3'd3, ST_DIV = 3'd4, ST_OUT = 3'd5;
	logic [2:0] st_q;
	logic [15:0] lst_q [MAX_ROW_LEN];
	logic [15:0] est_q [MAX_ROW_LEN];
	logic signed [15:0] max_q;
	logic [CW-1:0] cnt_q, idx_q;
	logic [20:0] sum_q;
	logic drop_q;
	logic [15:0] rd_q;
	logic [3:0] ph_q;
	logic [2:0] k_q;
	logic [5:0] n_q;
	logic [29:0] y_q;
	logic [30:0] r_q;
	logic [30:0] rr_q;
	logic [63:0] t_q;
	logic [36:0] num_q;
	logic [36:0] quo_q;
	logic [5:0] dbit_q;
	logic [15:0] po_q;
	logic lo_q, ov_q;
	logic [AW-1:0] ia;
	assign ia = idx_q[AW-1:0];
	assign q_ready = st_q == ST_LOAD;
	assign out_valid = st_q == ST_OUT;
	assign probability = po_q;
	assign last_of_row = lo_q;
	assign overflowed = ov_q;
	logic [16:0] xw;
	logic [60:0] yr;
	logic [30:0] rr;
	logic [63:0] qm;
	logic [30:0] qk;
	logic [20:0] half;
	logic [5:0] sh;
	logic [30:0] rnd;
	logic [21:0] sadd;
	assign xw = 17'($signed({max_q[15], max_q}) - $signed({rd_q[15], rd_q}));
	assign yr = 61'(y_q) * 61'(r_q);
	assign rr = 31'(yr >> 30);
	assign qm = 64'(rr_q) * 64'((k_q == 3'd5) ? RECIP5 : RECIP3);
	always_comb begin
		unique case (k_q)
		3'd2: qk = rr_q >> 1;
		3'd3: qk = 31'(qm >> 33);
		3'd4: qk = rr_q >> 2;
		3'd5, 3'd6: qk = 31'(qm >> 34);
		default: qk = rr_q;
		endcase
	end
	assign sh = n_q + 6'd14;
	assign rnd = 31'((31'(r_q) + (31'd1 << (sh - 6'd1))) >> sh);
	assign half = sum_q >> 1;
	assign sadd = 22'(sum_q) + 22'(est_q[ia]);
	always_ff @(posedge clk) begin
		if (st_q == ST_LOAD && q_valid && cnt_q < CW'(MAX_ROW_LEN))
			lst_q[cnt_q[AW-1:0]] <= q_item.logit;
		if (st_q == ST_RD || st_q == ST_DRD) rd_q <= lst_q[ia];
		if (st_q == ST_EXP && ph_q == 4'd9)
			est_q[ia] <= (n_q > 6'd16) ? 16'd0 : ((rnd > 31'd65535) ? 16'hFFFF : rnd[15:0]);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD; max_q <= 16'sh8000; cnt_q <= '0; sum_q <= '0;
			drop_q <= 1'b0; idx_q <= '0; ph_q <= '0;
		end else begin
			unique case (st_q)
			ST_LOAD: if (q_valid) begin
				if (cnt_q < CW'(MAX_ROW_LEN)) begin
					cnt_q <= cnt_q + 1'b1;
					if ($signed(q_item.logit) > max_q) max_q <= q_item.logit;
				end else drop_q <= 1'b1;
				if (q_item.row_end) begin
					idx_q <= '0; sum_q <= '0; st_q <= ST_RD;
				end
			end
			ST_RD: begin st_q <= ST_EXP; ph_q <= '0; end
			ST_EXP: begin
				unique case (ph_q)
				4'd0: begin t_q <= 64'(xw[15:0]) * 64'(LOG2E_Q22); ph_q <= 4'd1; end
				4'd1: begin
					n_q <= (t_q[63:30] > 34'd63) ? 6'd63 : t_q[35:30];
					t_q <= 64'(t_q[29:0]) * 64'(LN2_Q30); ph_q <= 4'd2;
				end
				4'd2: begin
					y_q <= t_q[59:30]; r_q <= 31'h40000000; k_q <= 3'd6; ph_q <= 4'd3;
				end
				4'd3: begin
					rr_q <= rr; ph_q <= 4'd4;
				end
				4'd4: begin
					r_q <= 31'h40000000 - qk;
					if (k_q == 3'd1) ph_q <= 4'd9;
					else begin k_q <= k_q - 3'd1; ph_q <= 4'd3; end
				end
				4'd9: begin
					ph_q <= 4'd10;
				end
				default: begin
					sum_q <= (sadd > 22'(EXP_SUM_MAX)) ? EXP_SUM_MAX : sadd[20:0];
					if (idx_q + 1'b1 == cnt_q) begin idx_q <= '0; st_q <= ST_DRD; end
					else begin idx_q <= idx_q + 1'b1; st_q <= ST_RD; end
				end
				endcase
			end
			ST_DRD: begin
				num_q <= 37'({est_q[ia], 16'd0}) + 37'(half);
				quo_q <= '0; dbit_q <= 6'd37; st_q <= ST_DIV; t_q <= '0;
			end
			ST_DIV: begin
				if (dbit_q == 6'd0) begin
					po_q <= (sum_q == '0) ? 16'd0 :
						((quo_q[36:16] != '0) ? 16'hFFFF : quo_q[15:0]);
					lo_q <= idx_q + 1'b1 == cnt_q; ov_q <= drop_q; st_q <= ST_OUT;
				end else begin
					if ((t_q[37:0] << 1 | 38'(num_q[36])) >= 38'(sum_q)) begin
						t_q <= 64'(((t_q[37:0] << 1) | 38'(num_q[36])) - 38'(sum_q));
						quo_q <= {quo_q[35:0], 1'b1};
					end else begin
						t_q <= 64'((t_q[37:0] << 1) | 38'(num_q[36]));
						quo_q <= {quo_q[35:0], 1'b0};
					end
					num_q <= num_q << 1; dbit_q <= dbit_q - 6'd1;
				end
			end
			ST_OUT: if (out_ready) begin
				if (lo_q) begin
					st_q <= ST_LOAD; max_q <= 16'sh8000; cnt_q <= '0; drop_q <= 1'b0;
					sum_q <= '0;
				end else begin idx_q <= idx_q + 1'b1; st_q <= ST_DRD; end
			end
			default: st_q <= ST_LOAD;
			endcase
		end
	end
endmodule

// ===== verif/softmax_row_normalizer_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of softmax_row_normalizer_core: rows of logits go in as words and
// each returned probability word is checked against a fixed-point softmax predictor.
// Depends on smx_pkg and the RTL of the core.
module softmax_row_normalizer_core_test;
	import smx_pkg::*;

	localparam int ROW_DEPTH = 16;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [15:0] probability;
		logic        last_of_row;
		logic        overflowed;
	} prob_word_t;

	class softmax_scoreboard;
		logic signed [15:0] row_logits[ROW_DEPTH];
		logic signed [15:0] row_max;
		int                 row_count;
		logic               row_dropped;
		prob_word_t         pending[$];

		function new();
			clear_row();
		endfunction

		function void clear_row();
			row_max = -16'sd32768;
			row_count = 0;
			row_dropped = 1'b0;
		endfunction

		function logic [15:0] exp_q16(logic [15:0] x);
			logic [63:0] t, n, f, y, r, v;
			int k;
			int s;
			t = 64'(x) * 64'(LOG2E_Q22);
			n = t >> 30;
			f = t & ((64'd1 << 30) - 64'd1);
			y = (f * 64'(LN2_Q30)) >> 30;
			r = 64'd1 << 30;
			for (k = 6; k >= 1; k--)
				r = (64'd1 << 30) - (((y * r) >> 30) / 64'(k));
			if (n > 16)
				return 16'd0;
			s = int'(n) + 14;
			v = (r + (64'd1 << (s - 1))) >> s;
			if (v > 64'd65535)
				v = 64'd65535;
			return v[15:0];
		endfunction

		function void note_word(logic [15:0] logit, logic row_end);
			logic [15:0] e[ROW_DEPTH];
			logic [63:0] sum, p;
			prob_word_t w;
			int i;
			if (row_count < ROW_DEPTH) begin
				row_logits[row_count] = logit;
				row_count++;
				if ($signed(logit) > row_max)
					row_max = logit;
			end else begin
				row_dropped = 1'b1;
			end
			if (!row_end)
				return;
			sum = 0;
			for (i = 0; i < row_count; i++) begin
				e[i] = exp_q16(16'(row_max - row_logits[i]));
				sum += 64'(e[i]);
				if (sum > 64'(EXP_SUM_MAX))
					sum = 64'(EXP_SUM_MAX);
			end
			for (i = 0; i < row_count; i++) begin
				p = 0;
				if (sum != 0) begin
					p = ((64'(e[i]) << 16) + sum / 2) / sum;
					if (p > 64'd65535)
						p = 64'd65535;
				end
				w.probability = p[15:0];
				w.last_of_row = (i + 1 == row_count);
				w.overflowed = row_dropped;
				pending.push_back(w);
			end
			clear_row();
		endfunction

		function string check_result(logic [15:0] prob, logic last, logic ovf);
			prob_word_t w;
			if (pending.size() == 0)
				return $sformatf("unexpected word prob=%0d last=%0b ovf=%0b", prob, last, ovf);
			w = pending.pop_front();
			if (prob !== w.probability || last !== w.last_of_row || ovf !== w.overflowed)
				return $sformatf("got prob=%0d last=%0b ovf=%0b, want %0d %0b %0b",
					prob, last, ovf, w.probability, w.last_of_row, w.overflowed);
			return "";
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	softmax_scoreboard sb;
	int  error_count = 0;
	int  words_in = 0;
	int  words_out = 0;
	int  rows_in = 0;
	int  idle_cycles = 0;
	bit  gaps_on = 1'b1;
	bit  held_off = 1'b0;

	softmax_row_normalizer_core #(.MAX_ROW_LEN(ROW_DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic report_mismatch(string msg);
		error_count++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	task automatic send_word(logic [15:0] logit, logic row_end);
		int gap;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = logit;
		s_tlast = row_end;
		do @(posedge clk); while (!s_tready);
		sb.note_word(logit, row_end);
		words_in++;
		if (row_end)
			rows_in++;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_row(int len, int spread);
		int i;
		logic [15:0] base, v;
		base = 16'($urandom);
		for (i = 0; i < len; i++) begin
			if (spread == 0)
				v = 16'($urandom);
			else
				v = base + 16'($urandom_range(0, spread));
			send_word(v, i == len - 1);
		end
	endtask

	always @(posedge clk) begin
		string msg;
		if (m_tvalid && m_tready) begin
			msg = sb.check_result(m_tdata, m_tlast, m_tuser);
			if (msg != "")
				report_mismatch(msg);
			words_out++;
		end
	end

	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && words_out >= 60) begin
				held_off = 1'b1;
				m_tready = 1'b0;
				repeat (400) @(negedge clk);
			end
			if (gaps_on && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 3);
				m_tready = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int i;
		sb = new();
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_word(16'h1234, 1'b1);
		send_word(16'h7FFF, 1'b0);
		send_word(16'h8000, 1'b1);
		send_word(16'h0000, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'h0000, 1'b1);
		send_word(16'h0100, 1'b0);
		send_word(16'hFF00, 1'b1);
		for (i = 0; i < 17; i++)
			send_word(16'(i * 37), i == 16);

		while (words_in < 480) begin
			case ($urandom_range(0, 9))
				0: send_row($urandom_range(15, 20), 0);
				1, 2: send_row($urandom_range(1, 8), 0);
				default: send_row($urandom_range(1, 8), $urandom_range(0, 2047));
			endcase
			if (words_in > 400)
				gaps_on = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.pending.size() != 0)
			report_mismatch($sformatf("%0d words never arrived", sb.pending.size()));
		$display("Sent %0d logit words in %0d rows, checked %0d probability words.",
			words_in, rows_in, words_out);
		$display("Rows covered single logits, full-range extremes and buffer overflow.");
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/smx_pkg.sv
hw/rtl/smx_front.sv
hw/rtl/smx_back.sv
hw/rtl/softmax_row_normalizer_core.sv
verif/softmax_row_normalizer_core_test.sv
